[rtl/oriented_rect_hit_test_top_assert.svh]
// Assertion macros shared by the hit test RTL.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ORIENTED_RECT_HIT_TEST_TOP_ASSERT_SVH
`define ORIENTED_RECT_HIT_TEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ORHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ORHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/orht_pkg.sv]
// Shared constants and types for the oriented rectangle hit test.
// No dependencies.
package orht_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_LOG2      = 23;
  localparam int SIN2_LOG2     = 22;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int NUM_W         = 64;
  // One extra quotient bit gives the doubled quotient used by the inside test.
  localparam int QUO_W         = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_AXIS_RIGHT_X = 3'd2,
    REG_AXIS_RIGHT_Y = 3'd3,
    REG_AXIS_UP_X    = 3'd4,
    REG_AXIS_UP_Y    = 3'd5,
    REG_EXTENT_X     = 3'd6,
    REG_EXTENT_Y     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic             rem_zero;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

[rtl/orht_div.sv]
// Pipelined restoring divider: a load stage, then one quotient bit per stage, stall by enable.
// Depends on orht_pkg and oriented_rect_hit_test_top_assert.svh.
`include "oriented_rect_hit_test_top_assert.svh"

module orht_div #(
  parameter int FRAC_BITS = orht_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [orht_pkg::NUM_W-1:0]   in_num,
  input  logic [TAG_W-1:0]             in_tag,
  input  logic [orht_pkg::NUM_W-1:0]   den,
  output orht_pkg::div_res_t           res,
  output logic [TAG_W-1:0]             out_tag
);

  localparam int NUM_W  = orht_pkg::NUM_W;
  localparam int QUO_W  = orht_pkg::QUO_W;
  localparam int EXT_W  = NUM_W + FRAC_BITS + 1;
  localparam int HI_W   = EXT_W - QUO_W;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] q;
    logic             sat;
    logic [TAG_W-1:0] tag;
  } stage_t;

  function automatic stage_t step_fn(stage_t s, logic [NUM_W-1:0] d);
    logic [NUM_W:0] t;
    logic [NUM_W:0] diff;
    logic           ge;
    stage_t         o;
    t    = {s.r, s.low[QUO_W-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    o       = s;
    o.r     = ge ? diff[NUM_W-1:0] : t[NUM_W-1:0];
    o.low   = {s.low[QUO_W-2:0], 1'b0};
    o.q     = {s.q[QUO_W-2:0], ge};
    return o;
  endfunction

  logic [EXT_W-1:0] num_ext;
  logic [NUM_W-1:0] hi_ext;
  logic             sat0;
  logic [QUO_W:0]   vld;
  stage_t           stg [0:QUO_W];

  // The numerator is the magnitude scaled by two units, so the quotient is doubled.
  assign num_ext = {in_num, {(FRAC_BITS + 1){1'b0}}};
  assign hi_ext  = NUM_W'(num_ext[EXT_W-1:QUO_W]);
  assign sat0    = (hi_ext >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].r   <= sat0 ? '0 : hi_ext;
      stg[0].low <= num_ext[QUO_W-1:0];
      stg[0].q   <= '0;
      stg[0].sat <= sat0;
      stg[0].tag <= in_tag;
      for (int k = 1; k <= QUO_W; k++) begin
        stg[k] <= step_fn(stg[k-1], den);
      end
    end
  end

  assign res.valid    = vld[QUO_W];
  assign res.sat      = stg[QUO_W].sat;
  assign res.rem_zero = (stg[QUO_W].r == '0);
  assign res.quo      = stg[QUO_W].q;
  assign out_tag      = stg[QUO_W].tag;

  `ORHT_ASSERT_NOW(a_div_rem, vld[QUO_W] && !stg[QUO_W].sat, stg[QUO_W].r < den, "remainder not below divisor")

endmodule

[rtl/oriented_rect_hit_test_top.sv]
// Top level of the oriented rectangle hit test: config registers, pose
// derivation, point transform pipeline and output skid buffer. Uses orht_pkg, orht_div.
// A request passes the input, offset, product and magnitude registers, then both dividers.
// Throughput: one point per clock while the output buffer is not full; two 34-stage dividers set the depth.
// After a config write, pose terms pass the product, sum, partial product and full product registers to pose_ok.
// Reset (synchronous): valids and buffer cleared, identity axes, zero centre and extents.
`include "oriented_rect_hit_test_top_assert.svh"

module oriented_rect_hit_test_top #(
  parameter int FRAC_BITS = orht_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [orht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [orht_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // canvas_x, canvas_y
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [63:0]                     m_axis_tdata,  // local_x, local_y
  output logic [1:0]                      m_axis_tuser   // local_valid, inside_res
);

  localparam int NUM_W     = orht_pkg::NUM_W;
  localparam int QUO_W     = orht_pkg::QUO_W;
  localparam int SHIFT     = 4 * FRAC_BITS - 2 * orht_pkg::EPS_LOG2;
  localparam int SHIFT_POS = (SHIFT < 0) ? 0 : SHIFT;
  localparam logic [127:0] THR = (SHIFT < 0) ? 128'd0 : (128'd1 << SHIFT_POS);

  typedef struct packed {
    logic [31:0] local_x;
    logic [31:0] local_y;
    logic        inside_res;
    logic        local_valid;
  } out_t;

  function automatic logic [31:0] to_fixed(logic [31:0] q, logic neg, logic sat);
    logic [31:0] r;
    if (!neg) begin
      r = (sat || q[31]) ? 32'h7FFF_FFFF : q;
    end else begin
      r = (sat || q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q);
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [31:0] center_x, center_y, axis_right_x, axis_right_y;
  logic signed [31:0] axis_up_x, axis_up_y, extent_x, extent_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      axis_right_x <= 32'sd1 <<< FRAC_BITS;
      axis_right_y <= '0;
      axis_up_x    <= '0;
      axis_up_y    <= 32'sd1 <<< FRAC_BITS;
      extent_x     <= '0;
      extent_y     <= '0;
    end else if (cfg_we) begin
      case (orht_pkg::cfg_reg_t'(cfg_index))
        orht_pkg::REG_CENTER_X:     center_x     <= cfg_data;
        orht_pkg::REG_CENTER_Y:     center_y     <= cfg_data;
        orht_pkg::REG_AXIS_RIGHT_X: axis_right_x <= cfg_data;
        orht_pkg::REG_AXIS_RIGHT_Y: axis_right_y <= cfg_data;
        orht_pkg::REG_AXIS_UP_X:    axis_up_x    <= cfg_data;
        orht_pkg::REG_AXIS_UP_Y:    axis_up_y    <= cfg_data;
        orht_pkg::REG_EXTENT_X:     extent_x     <= cfg_data;
        orht_pkg::REG_EXTENT_Y:     extent_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pose terms run freely from the config registers; the user must change them only while idle (not enforced).
  logic signed [63:0] sq_rx, sq_ry, sq_ux, sq_uy, pa, pb;
  logic [63:0]        lr2, lu2, dmag;
  logic signed [64:0] d_s;
  logic               dneg;
  logic [63:0]        pp [0:7];
  logic [127:0]       p_len, dd;
  logic               pose_ok;
  logic [64:0]        d_neg_val;
  logic [31:0]        ex_mag, ey_mag;

  assign d_s       = {pa[63], pa} - {pb[63], pb};
  assign d_neg_val = 65'd0 - d_s;

  always_ff @(posedge clk) begin
    sq_rx <= axis_right_x * axis_right_x;
    sq_ry <= axis_right_y * axis_right_y;
    sq_ux <= axis_up_x * axis_up_x;
    sq_uy <= axis_up_y * axis_up_y;
    pa    <= axis_right_x * axis_up_y;
    pb    <= axis_right_y * axis_up_x;
    lr2   <= $unsigned(sq_rx) + $unsigned(sq_ry);
    lu2   <= $unsigned(sq_ux) + $unsigned(sq_uy);
    dneg  <= d_s[64];
    dmag  <= d_s[64] ? d_neg_val[63:0] : d_s[63:0];
    pp[0] <= lr2[31:0] * lu2[31:0];
    pp[1] <= lr2[31:0] * lu2[63:32];
    pp[2] <= lr2[63:32] * lu2[31:0];
    pp[3] <= lr2[63:32] * lu2[63:32];
    pp[4] <= dmag[31:0] * dmag[31:0];
    pp[5] <= dmag[31:0] * dmag[63:32];
    pp[6] <= dmag[63:32] * dmag[31:0];
    pp[7] <= dmag[63:32] * dmag[63:32];
    p_len <= 128'(pp[0]) + (128'(pp[1]) << 32) + (128'(pp[2]) << 32) + (128'(pp[3]) << 64);
    dd    <= 128'(pp[4]) + (128'(pp[5]) << 32) + (128'(pp[6]) << 32) + (128'(pp[7]) << 64);
    // Degenerate scale, then near-parallel axes.
    pose_ok <= (p_len > THR) && (dd > (p_len >> orht_pkg::SIN2_LOG2));
  end

  assign ex_mag = extent_x[31] ? (32'd0 - extent_x) : extent_x;
  assign ey_mag = extent_y[31] ? (32'd0 - extent_y) : extent_y;

  // Point pipeline; every stage moves on adv.
  logic [1:0]         cnt;
  logic               adv;
  logic               v0, v1, v2, v3;
  logic signed [31:0] cx0, cy0;
  logic signed [32:0] ox1, oy1;
  logic signed [64:0] ma2, mb2, mc2, md2;
  logic signed [65:0] nxs, nys;
  logic [65:0]        nxn, nyn;
  logic [63:0]        nx3, ny3;
  logic               negx3, negy3;

  assign adv           = (cnt != 2'd2);
  assign s_axis_tready = adv;

  assign nxs = {ma2[64], ma2} - {mb2[64], mb2};
  assign nys = {mc2[64], mc2} - {md2[64], md2};
  assign nxn = 66'd0 - nxs;
  assign nyn = 66'd0 - nys;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx0   <= s_axis_tdata[31:0];
      cy0   <= s_axis_tdata[63:32];
      ox1   <= {cx0[31], cx0} - {center_x[31], center_x};
      oy1   <= {cy0[31], cy0} - {center_y[31], center_y};
      ma2   <= ox1 * axis_up_y;
      mb2   <= oy1 * axis_up_x;
      mc2   <= oy1 * axis_right_x;
      md2   <= ox1 * axis_right_y;
      negx3 <= nxs[65];
      negy3 <= nys[65];
      nx3   <= nxs[65] ? nxn[63:0] : nxs[63:0];
      ny3   <= nys[65] ? nyn[63:0] : nys[63:0];
    end
  end

  orht_pkg::div_res_t res_x, res_y;
  logic               tag_x, tag_y;

  orht_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3), .in_num(nx3), .in_tag(negx3),
    .den(dmag), .res(res_x), .out_tag(tag_x)
  );

  orht_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(1)) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3), .in_num(ny3), .in_tag(negy3),
    .den(dmag), .res(res_y), .out_tag(tag_y)
  );

  // Final result. The doubled quotient compared with the extent gives the
  // half-extent test; the y test also admits an exact tie.
  out_t        res_new;
  logic        inx, iny;
  logic [31:0] qx, qy;

  assign qx  = res_x.quo[QUO_W-1:1];
  assign qy  = res_y.quo[QUO_W-1:1];
  assign inx = !res_x.sat && (res_x.quo < {1'b0, ex_mag});
  assign iny = !res_y.sat && ((res_y.quo < {1'b0, ey_mag}) ||
               ((res_y.quo == {1'b0, ey_mag}) && res_y.rem_zero));

  always_comb begin
    res_new = '0;
    if (pose_ok) begin
      res_new.local_x     = to_fixed(qx, tag_x ^ dneg, res_x.sat);
      res_new.local_y     = to_fixed(qy, tag_y ^ dneg, res_y.sat);
      res_new.local_valid = 1'b1;
      res_new.inside_res  = inx && iny;
    end
  end

  // Two-entry output buffer; the pipeline stalls only when both are full.
  out_t ent0, ent1;
  logic push, pop;

  assign push = adv && res_x.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent0 <= (push && cnt == 2'd1) ? res_new : ent1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        ent0 <= res_new;
      end else begin
        ent1 <= res_new;
      end
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = {ent0.local_y, ent0.local_x};
  assign m_axis_tuser  = {ent0.inside_res, ent0.local_valid};

  `ORHT_ASSERT_NOW(a_cnt_range, 1'b1, cnt != 2'd3, "output buffer count out of range")
  `ORHT_ASSERT_NOW(a_lanes_align, 1'b1, res_x.valid == res_y.valid, "divider lanes out of step")
  `ORHT_ASSERT_NOW(a_inside_valid, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "inside without valid pose")
  `ORHT_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "invalid pose with nonzero coordinates")

endmodule

[test/tb.sv]
// Self-checking testbench for oriented_rect_hit_test_top: an in-bench predictor
// works out each point's local coordinates and flags, and a checker compares them.
// Depends on orht_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;

  localparam int HALF_PERIOD = 10;
  localparam int LATENCY     = 38;
  localparam int SETTLE      = 60;
  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int SCALE_SH    = 4 * orht_pkg::FRAC_BITS_DEF - 2 * orht_pkg::EPS_LOG2;

  typedef struct packed {
    logic [31:0] lx;
    logic [31:0] ly;
    logic        valid;
    logic        hit;
  } hit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [orht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [orht_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic [31:0] pose [8];
  hit_t        hits_due [$];
  int          errors = 0;
  int          hold_off = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          ready_pct = 70;
  bit          no_gaps = 0;
  int          idle_cycles = 0;

  oriented_rect_hit_test_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),   // canvas_x, canvas_y
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),   // local_x, local_y
    .m_axis_tuser(m_axis_tuser)    // local_valid, inside_res
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [31:0] to_q16(logic [127:0] q, bit neg);
    if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    if (q > 128'h80000000) return 32'h80000000;
    return 32'(-q);
  endfunction

  function automatic hit_t locate_point(logic [31:0] px, logic [31:0] py);
    logic signed [127:0] rx, ry, ux, uy, ox, oy, ex, ey, dd, nxs, nys;
    logic [127:0] lr2, lu2, p, d, nx, ny;
    hit_t h;
    rx = $signed(pose[orht_pkg::REG_AXIS_RIGHT_X]);
    ry = $signed(pose[orht_pkg::REG_AXIS_RIGHT_Y]);
    ux = $signed(pose[orht_pkg::REG_AXIS_UP_X]);
    uy = $signed(pose[orht_pkg::REG_AXIS_UP_Y]);
    ox = $signed(px);
    ox = ox - $signed(pose[orht_pkg::REG_CENTER_X]);
    oy = $signed(py);
    oy = oy - $signed(pose[orht_pkg::REG_CENTER_Y]);
    ex = $signed(pose[orht_pkg::REG_EXTENT_X]);
    ey = $signed(pose[orht_pkg::REG_EXTENT_Y]);
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    lr2 = rx * rx + ry * ry;
    lu2 = ux * ux + uy * uy;
    p = lr2 * lu2;
    dd  = rx * uy - ry * ux;
    nxs = ox * uy - oy * ux;
    nys = rx * oy - ry * ox;
    d  = (dd < 0) ? -dd : dd;
    nx = (nxs < 0) ? -nxs : nxs;
    ny = (nys < 0) ? -nys : nys;
    h = '0;
    // Tiny scale or nearly parallel axes make the pose unusable.
    if (SCALE_SH < 0 ? p == 0 : p <= (128'd1 << SCALE_SH)) return h;
    if (d * d <= (p >> orht_pkg::SIN2_LOG2)) return h;
    h.valid = 1'b1;
    h.lx    = to_q16((nx << orht_pkg::FRAC_BITS_DEF) / d, (nxs < 0) != (dd < 0));
    h.ly    = to_q16((ny << orht_pkg::FRAC_BITS_DEF) / d, (nys < 0) != (dd < 0));
    h.hit   = ((nx << (orht_pkg::FRAC_BITS_DEF + 1)) < ex * d) &&
              ((ny << (orht_pkg::FRAC_BITS_DEF + 1)) <= ey * d);
    return h;
  endfunction

  task automatic wait_idle();
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes a whole pose; only called with nothing in flight.
  task automatic load_pose(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= orht_pkg::cfg_reg_t'(i);
      cfg_data  <= v[i];
      pose[i] = v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (SETTLE) @(posedge clk);
  endtask

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_point(logic [31:0] px, logic [31:0] py);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk); while (!s_axis_tready);
    hits_due.insert(hits_due.size(), locate_point(px, py));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] near(logic [31:0] c, int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  // Receiver readiness, with occasional long stalls.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_off <= $urandom_range(10, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    hit_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hits_due.size() == 0) begin
        $error("result with no request outstanding: %h %b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = hits_due.pop_front();
        if (m_axis_tdata[31:0] !== want.lx) begin
          $error("local_x expected %h got %h", want.lx, m_axis_tdata[31:0]); errors++;
        end
        if (m_axis_tdata[63:32] !== want.ly) begin
          $error("local_y expected %h got %h", want.ly, m_axis_tdata[63:32]); errors++;
        end
        if (m_axis_tuser[0] !== want.valid) begin
          $error("local_valid expected %b got %b", want.valid, m_axis_tuser[0]); errors++;
        end
        if (m_axis_tuser[1] !== want.hit) begin
          $error("inside_res expected %b got %b", want.hit, m_axis_tuser[1]); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_reset_pose();
    // Identity axes and zero extent: nothing is inside, not even the centre.
    send_point(32'h0, 32'h0);
    send_point(32'h0001_8000, 32'hFFFE_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    stop_sending();
    wait_idle();
  endtask

  task automatic test_edges();
    logic [31:0] v [8];
    v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000,
          32'h0002_0000, 32'hFFFE_0000};
    load_pose(v);
    // The x bound is strict and the y bound inclusive.
    send_point(32'h0001_0000, 32'h0);
    send_point(32'hFFFF_0000, 32'h0);
    send_point(32'h0, 32'h0001_0000);
    send_point(32'h0, 32'hFFFF_0000);
    send_point(32'h0000_FFFF, 32'h0001_0000);
    send_point(32'h0000_FFFF, 32'h0001_0001);
    stop_sending();
    wait_idle();
    // Small axes push the quotient out of range in both directions.
    v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0, 32'h0, 32'hFFFF_FF00,
          32'h7FFF_FFFF, 32'h8000_0000};
    load_pose(v);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0100, 32'h7FFF_FF00);
    stop_sending();
    wait_idle();
  endtask

  task automatic test_degenerate();
    logic [31:0] v [8];
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0004_0000, 32'h0004_0000};
    load_pose(v);
    send_point(32'h0, 32'h0);
    send_point(32'h1234_5678, 32'h8765_4321);
    stop_sending();
    wait_idle();
    // Parallel axes.
    v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFE_0000,
          32'h0004_0000, 32'h0004_0000};
    load_pose(v);
    send_point(32'h0, 32'h0);
    stop_sending();
    wait_idle();
    // Tiny but independent axes, below the scale threshold.
    v = '{32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0004_0000, 32'h0004_0000};
    load_pose(v);
    send_point(32'h0, 32'h1);
    stop_sending();
    wait_idle();
    // Largest magnitudes in every register.
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    load_pose(v);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    stop_sending();
    wait_idle();
  endtask

  task automatic random_pose(output logic [31:0] v [8]);
    int kind;
    kind = $urandom_range(0, 9);
    v[orht_pkg::REG_CENTER_X] = near(32'h0, 1 << 24);
    v[orht_pkg::REG_CENTER_Y] = near(32'h0, 1 << 24);
    for (int i = 2; i < 6; i++) v[i] = near(32'h0, 1 << 17);
    v[orht_pkg::REG_EXTENT_X] = near(32'h0, 1 << 19);
    v[orht_pkg::REG_EXTENT_Y] = near(32'h0, 1 << 19);
    if (kind == 0) begin
      for (int i = 0; i < 8; i++) v[i] = $urandom;
    end else if (kind == 1) begin
      // Up axis a multiple of the right axis.
      v[orht_pkg::REG_AXIS_UP_X] = v[orht_pkg::REG_AXIS_RIGHT_X] * 3;
      v[orht_pkg::REG_AXIS_UP_Y] = v[orht_pkg::REG_AXIS_RIGHT_Y] * 3;
    end
  endtask

  task automatic test_random(int poses, int per_pose);
    logic [31:0] v [8];
    for (int k = 0; k < poses; k++) begin
      random_pose(v);
      load_pose(v);
      ready_pct = $urandom_range(0, 3) == 0 ? 100 : $urandom_range(30, 95);
      for (int n = 0; n < per_pose; n++) begin
        if ($urandom_range(0, 99) < 15)
          send_point($urandom, $urandom);
        else
          send_point(near(pose[orht_pkg::REG_CENTER_X], 1 << 19),
                     near(pose[orht_pkg::REG_CENTER_Y], 1 << 19));
      end
      stop_sending();
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    // The receiver stalls long enough for the pipeline to fill and refuse requests.
    no_gaps = 1;
    hold_req++;
    for (int n = 0; n < 80; n++)
      send_point(near(pose[orht_pkg::REG_CENTER_X], 1 << 19),
                 near(pose[orht_pkg::REG_CENTER_Y], 1 << 19));
    stop_sending();
    no_gaps = 0;
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pose[i] = 32'h0;
    pose[orht_pkg::REG_AXIS_RIGHT_X] = 32'h0001_0000;
    pose[orht_pkg::REG_AXIS_UP_Y]    = 32'h0001_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_pose();
    test_edges();
    test_degenerate();
    test_random(12, 42);
    test_backpressure();
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && hits_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/orht_pkg.sv
rtl/orht_div.sv
rtl/oriented_rect_hit_test_top.sv
test/tb.sv
